FILE: hdl/tbma_pkg.sv
package tbma_pkg;

   localparam int TEMP_FRAC_BITS_DEF = 6;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE_MS  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEMP_CEILING = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAS_CEILING  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAS_STEP     = 2'd3;

   localparam logic [15:0] DEBOUNCE_MS_RST  = 16'd50;
   localparam logic [6:0]  TEMP_CEILING_RST = 7'd50;
   localparam logic [9:0]  GAS_CEILING_RST  = 10'd1000;
   localparam logic [7:0]  GAS_STEP_RST     = 8'd10;

   localparam logic [6:0]  TEMP_LIMIT_RST = 7'd35;
   localparam logic [9:0]  GAS_LIMIT_RST  = 10'd900;

   localparam logic [1:0] SCREEN_MAIN     = 2'd0;
   localparam logic [1:0] SCREEN_READINGS = 2'd1;
   localparam logic [1:0] SCREEN_THRESH   = 2'd2;
   localparam logic [1:0] SCREEN_STATUS   = 2'd3;

   localparam logic [1:0] OPTION_FIRST  = 2'd0;
   localparam logic [1:0] OPTION_SECOND = 2'd1;
   localparam logic [1:0] OPTION_THIRD  = 2'd2;

   localparam logic [5:0] VENT_MAX = 6'd45;

   // x/10 for x < 1024 as (x*205) >> 11
   localparam int GAS_RECIP       = 205;
   localparam int GAS_RECIP_SHIFT = 11;
   localparam int GAS_HALF_STEP   = 5;

   // a*100/45 for a <= 45 as (a*2276) >> 10
   localparam int PCT_RECIP       = 2276;
   localparam int PCT_RECIP_SHIFT = 10;

   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 40;

   typedef struct packed {
      logic [15:0] debounce_ms;
      logic [6:0]  temp_ceiling;
      logic [9:0]  gas_ceiling;
      logic [7:0]  gas_step;
   } cfg_type;

   typedef struct packed {
      logic       press_a;
      logic       press_b;
      logic [1:0] screen;
      logic [1:0] option;
      logic       editing;
      logic [6:0] temp_limit;
      logic [9:0] gas_limit;
   } menu_status_type;

   typedef struct packed {
      logic       alarm_on;
      logic [5:0] vent_angle;
      logic       vent_update;
      logic [6:0] vent_percent;
   } vent_status_type;

   function automatic logic [6:0] vent_percent_of(input logic [5:0] angle);
      logic [17:0] prod;
      prod = 18'(angle) * 18'(PCT_RECIP);
      return prod[PCT_RECIP_SHIFT +: 7];
   endfunction

endpackage

FILE: hdl/tbma_menu.sv
module tbma_menu
   import tbma_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  logic            button_a_level,
   input  logic            button_b_level,
   input  cfg_type         cfg,
   output menu_status_type status
);

   logic [15:0] elapsed_ff, elapsed_in;
   logic        stable_a_ff, stable_a_in;
   logic        stable_b_ff, stable_b_in;
   logic [1:0]  screen_ff, screen_in;
   logic [1:0]  option_ff, option_in;
   logic        edit_ff, edit_in;
   logic [6:0]  temp_thr_ff, temp_thr_in;
   logic [9:0]  gas_thr_ff, gas_thr_in;

   logic [15:0] elapsed_inc;
   logic        lock_open;
   logic        press_a, release_a, press_b, release_b;
   logic [7:0]  temp_sum;
   logic [10:0] gas_sum;
   logic [1:0]  option_a;

   always_comb begin
      elapsed_inc = (elapsed_ff != 16'hFFFF) ? elapsed_ff + 16'd1 : elapsed_ff;
      lock_open   = elapsed_inc >= cfg.debounce_ms;
      press_a     = lock_open && !button_a_level && stable_a_ff;
      release_a   = lock_open && button_a_level && !stable_a_ff;
      press_b     = lock_open && !button_b_level && stable_b_ff;
      release_b   = lock_open && button_b_level && !stable_b_ff;

      elapsed_in  = (press_a || release_a || press_b || release_b) ? 16'd0 : elapsed_inc;
      stable_a_in = (press_a || release_a) ? button_a_level : stable_a_ff;
      stable_b_in = (press_b || release_b) ? button_b_level : stable_b_ff;

      screen_in   = screen_ff;
      option_in   = option_ff;
      edit_in     = edit_ff;
      temp_thr_in = temp_thr_ff;
      gas_thr_in  = gas_thr_ff;

      temp_sum = {1'b0, temp_thr_ff} + 8'd1;
      gas_sum  = {1'b0, gas_thr_ff} + {3'b000, cfg.gas_step};

      case (option_ff)
         OPTION_FIRST:  option_a = OPTION_SECOND;
         OPTION_SECOND: option_a = OPTION_THIRD;
         OPTION_THIRD:  option_a = OPTION_FIRST;
         default:       option_a = OPTION_SECOND;
      endcase

      // button one first
      if (press_a) begin
         if (!edit_ff) begin
            option_in = option_a;
         end else if (screen_ff == SCREEN_THRESH) begin
            if (option_ff == OPTION_FIRST) begin
               temp_thr_in = (temp_sum > {1'b0, cfg.temp_ceiling}) ?
                             cfg.temp_ceiling : temp_sum[6:0];
            end else begin
               gas_thr_in = (gas_sum > {1'b0, cfg.gas_ceiling}) ?
                            cfg.gas_ceiling : gas_sum[9:0];
            end
         end
      end

      if (press_b) begin
         case (screen_ff)
            SCREEN_MAIN: begin
               case (option_in)
                  OPTION_FIRST:  screen_in = SCREEN_READINGS;
                  OPTION_SECOND: begin
                     screen_in = SCREEN_THRESH;
                     option_in = OPTION_FIRST;
                  end
                  OPTION_THIRD:  screen_in = SCREEN_STATUS;
                  default:       screen_in = screen_ff;
               endcase
            end
            SCREEN_THRESH: begin
               if (edit_in) begin
                  edit_in   = 1'b0;
                  option_in = {1'b0, ~option_in[0]};
               end else begin
                  edit_in = 1'b1;
               end
            end
            default: begin
               screen_in = SCREEN_MAIN;
               option_in = OPTION_FIRST;
            end
         endcase
      end

      status.press_a    = press_a;
      status.press_b    = press_b;
      status.screen     = screen_in;
      status.option     = option_in;
      status.editing    = edit_in;
      status.temp_limit = temp_thr_in;
      status.gas_limit  = gas_thr_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff  <= 16'd0;
         stable_a_ff <= 1'b1;
         stable_b_ff <= 1'b1;
         screen_ff   <= SCREEN_MAIN;
         option_ff   <= OPTION_FIRST;
         edit_ff     <= 1'b0;
         temp_thr_ff <= TEMP_LIMIT_RST;
         gas_thr_ff  <= GAS_LIMIT_RST;
      end else if (advance) begin
         elapsed_ff  <= elapsed_in;
         stable_a_ff <= stable_a_in;
         stable_b_ff <= stable_b_in;
         screen_ff   <= screen_in;
         option_ff   <= option_in;
         edit_ff     <= edit_in;
         temp_thr_ff <= temp_thr_in;
         gas_thr_ff  <= gas_thr_in;
      end
   end

endmodule

FILE: hdl/tbma_vent.sv
module tbma_vent
   import tbma_pkg::*;
#(
   parameter int TEMP_FRAC_BITS = TEMP_FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               sample_valid,
   input  logic signed [15:0] temp_fixed,
   input  logic [9:0]         gas_level,
   input  logic [6:0]         temp_limit,
   input  logic [9:0]         gas_limit,
   output vent_status_type    status
);

   localparam int THR_W  = 7 + TEMP_FRAC_BITS + 1;
   localparam int DT_W   = ((THR_W > 16) ? THR_W : 16) + 1;
   localparam int PROD_W = DT_W + 4;

   logic       alarm_ff, alarm_in;
   logic [5:0] angle_ff, angle_in;
   logic       update;

   logic signed [DT_W-1:0] temp_ext, thr_ext, dt;
   logic signed [10:0]     dg;
   logic [PROD_W-1:0]      prod, tv_full;
   logic [5:0]             tv;
   logic [17:0]            gq_prod;
   logic [6:0]             gq;
   logic [8:0]             gv, ang;
   logic                   hit;

   always_comb begin
      temp_ext = DT_W'(temp_fixed);
      thr_ext  = DT_W'(temp_limit) << TEMP_FRAC_BITS;
      dt       = temp_ext - thr_ext;
      dg       = $signed({1'b0, gas_level}) - $signed({1'b0, gas_limit});
      hit      = !dt[DT_W-1] || !dg[10];

      prod    = (dt > 0) ? PROD_W'(dt) * PROD_W'(10) : '0;
      tv_full = prod >> TEMP_FRAC_BITS;
      tv      = (tv_full > PROD_W'(VENT_MAX)) ? VENT_MAX : tv_full[5:0];

      gq_prod = (dg > 0) ? 18'(dg[9:0]) * 18'(GAS_RECIP) : 18'd0;
      gq      = gq_prod[GAS_RECIP_SHIFT +: 7];
      gv      = 9'(gq) * 9'(GAS_HALF_STEP);

      ang = (9'(tv) > gv) ? 9'(tv) : gv;
      if (ang > 9'(VENT_MAX)) begin
         ang = 9'(VENT_MAX);
      end

      alarm_in = alarm_ff;
      angle_in = angle_ff;
      update   = 1'b0;
      if (sample_valid) begin
         if (hit) begin
            alarm_in = 1'b1;
            angle_in = ang[5:0];
            update   = 1'b1;
         end else if (alarm_ff) begin
            alarm_in = 1'b0;
            angle_in = 6'd0;
            update   = 1'b1;
         end
      end

      status.alarm_on     = alarm_in;
      status.vent_angle   = angle_in;
      status.vent_update  = update;
      status.vent_percent = vent_percent_of(angle_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alarm_ff <= 1'b0;
         angle_ff <= 6'd0;
      end else if (advance) begin
         alarm_ff <= alarm_in;
         angle_ff <= angle_in;
      end
   end

endmodule

FILE: hdl/two_button_menu_threshold_alarm.sv
// Button menu and threshold alarm, one beat per millisecond tick. Each request
// beat carries both raw button levels and, when req_tuser is set, a sensor
// sample; it yields exactly one response beat with the debounced presses, the
// menu state, both thresholds, the alarm and the vent command. A beat sits in
// an input register while the debounce, menu and alarm logic updates its state
// in a single pass, and the result lands in an output register. A new beat is
// taken every cycle unless the output register holds an untaken beat; the
// state update loop sets the throughput. Configuration writes on the csr_
// channel are registered, apply from the next cycle and are always accepted.
module two_button_menu_threshold_alarm
   import tbma_pkg::*;
#(
   parameter int TEMP_FRAC_BITS = TEMP_FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_tvalid,
   output logic                   req_tready,
   // button_a_level, button_b_level, temp_fixed[15:0], gas_level[9:0], zero pad
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // sample_valid
   input  logic                   req_tuser,

   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // press_a, press_b, menu_screen[1:0], menu_option[1:0], editing,
   // temp_limit[6:0], gas_limit[9:0], alarm_on, vent_angle[5:0], vent_update,
   // vent_percent[6:0], zero pad
   output logic [RSP_TDATA_W-1:0] rsp_tdata,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type cfg_ff, cfg_in;

   logic               in_valid_ff;
   logic               lvl_a_ff, lvl_b_ff, sample_ff;
   logic signed [15:0] temp_ff;
   logic [9:0]         gas_ff;

   logic                   out_valid_ff;
   logic [RSP_TDATA_W-1:0] out_data_ff, out_data_in;

   logic            advance;
   menu_status_type menu;
   vent_status_type vent;

   assign csr_ready  = 1'b1;
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_DEBOUNCE_MS:  cfg_in.debounce_ms  = csr_data;
            CSR_TEMP_CEILING: cfg_in.temp_ceiling = csr_data[6:0];
            CSR_GAS_CEILING:  cfg_in.gas_ceiling  = csr_data[9:0];
            CSR_GAS_STEP:     cfg_in.gas_step     = csr_data[7:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms  <= DEBOUNCE_MS_RST;
         cfg_ff.temp_ceiling <= TEMP_CEILING_RST;
         cfg_ff.gas_ceiling  <= GAS_CEILING_RST;
         cfg_ff.gas_step     <= GAS_STEP_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         lvl_a_ff  <= req_tdata[0];
         lvl_b_ff  <= req_tdata[1];
         temp_ff   <= req_tdata[17:2];
         gas_ff    <= req_tdata[27:18];
         sample_ff <= req_tuser;
      end
   end

   tbma_menu u_menu (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .button_a_level (lvl_a_ff),
      .button_b_level (lvl_b_ff),
      .cfg            (cfg_ff),
      .status         (menu)
   );

   tbma_vent #(
      .TEMP_FRAC_BITS (TEMP_FRAC_BITS)
   ) u_vent (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .sample_valid (sample_ff),
      .temp_fixed   (temp_ff),
      .gas_level    (gas_ff),
      .temp_limit   (menu.temp_limit),
      .gas_limit    (menu.gas_limit),
      .status       (vent)
   );

   assign out_data_in = {1'b0, vent.vent_percent, vent.vent_update, vent.vent_angle,
                         vent.alarm_on, menu.gas_limit, menu.temp_limit, menu.editing,
                         menu.option, menu.screen, menu.press_b, menu.press_a};

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   a_stall_only_on_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("request side stalled without a blocked response beat");

   a_advance_gives_beat: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid)
      else $error("processed beat produced no response");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[30:25] <= VENT_MAX))
      else $error("vent angle above limit");

   a_idle_vent_closed: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[24]) |-> (rsp_tdata[30:25] == 6'd0))
      else $error("vent open while alarm is off");

   a_edit_on_thresholds: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[6]) |-> (rsp_tdata[3:2] == SCREEN_THRESH))
      else $error("editing outside the threshold screen");

endmodule

FILE: tb/two_button_menu_threshold_alarm_tb.sv
`timescale 1ns / 1ps

module two_button_menu_threshold_alarm_tb;
   import tbma_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TEMP_LO = -3200;
   localparam int TEMP_HI = 28800;
   localparam int GAS_HI  = 1023;

   typedef struct {
      bit               level_a;
      bit               level_b;
      bit               sample;
      logic signed [15:0] temp;
      logic [9:0]       gas;
   } tick_type;

   // rsp_tdata layout, last field in the lowest bits
   typedef struct packed {
      logic       pad;
      logic [6:0] vent_percent;
      logic       vent_update;
      logic [5:0] vent_angle;
      logic       alarm_on;
      logic [9:0] gas_limit;
      logic [6:0] temp_limit;
      logic       editing;
      logic [1:0] menu_option;
      logic [1:0] menu_screen;
      logic       press_b;
      logic       press_a;
   } panel_status_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tuser  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = CSR_DEBOUNCE_MS;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   two_button_menu_threshold_alarm i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   tick_type         tick_q[$];
   panel_status_type expected_status_q[$];
   int               n_queued;
   int               n_accepted;
   int               n_checked;
   int               n_err;
   int               quiet_cycles;

   // configuration copy
   logic [15:0] cfg_debounce  = DEBOUNCE_MS_RST;
   logic [6:0]  cfg_temp_ceil = TEMP_CEILING_RST;
   logic [9:0]  cfg_gas_ceil  = GAS_CEILING_RST;
   logic [7:0]  cfg_gas_step  = GAS_STEP_RST;

   // panel state copy
   int unsigned elapsed_cnt = 0;
   bit          held_a      = 1'b1;
   bit          held_b      = 1'b1;
   logic [1:0]  menu_scr    = SCREEN_MAIN;
   logic [1:0]  menu_line   = OPTION_FIRST;
   bit          edit_on     = 1'b0;
   logic [6:0]  temp_thr    = TEMP_LIMIT_RST;
   logic [9:0]  gas_thr     = GAS_LIMIT_RST;
   bit          alarm       = 1'b0;
   logic [5:0]  servo       = '0;

   // stimulus button levels
   bit gen_a = 1'b1;
   bit gen_b = 1'b1;

   function automatic void step_line_or_raise();
      int unsigned nxt;
      if (!edit_on) begin
         menu_line = (menu_line == OPTION_THIRD) ? OPTION_FIRST : menu_line + 2'd1;
      end else if (menu_scr == SCREEN_THRESH) begin
         if (menu_line == OPTION_FIRST) begin
            nxt = temp_thr + 1;
            if (nxt > cfg_temp_ceil) nxt = cfg_temp_ceil;
            temp_thr = 7'(nxt);
         end else begin
            nxt = gas_thr + cfg_gas_step;
            if (nxt > cfg_gas_ceil) nxt = cfg_gas_ceil;
            gas_thr = 10'(nxt);
         end
      end
   endfunction

   function automatic void navigate_screens();
      case (menu_scr)
         SCREEN_MAIN: begin
            if (menu_line == OPTION_FIRST) begin
               menu_scr = SCREEN_READINGS;
            end else if (menu_line == OPTION_SECOND) begin
               menu_scr  = SCREEN_THRESH;
               menu_line = OPTION_FIRST;
            end else if (menu_line == OPTION_THIRD) begin
               menu_scr = SCREEN_STATUS;
            end
         end
         SCREEN_THRESH: begin
            if (edit_on) begin
               edit_on   = 1'b0;
               menu_line = (menu_line == OPTION_SECOND) ? OPTION_FIRST : OPTION_SECOND;
            end else begin
               edit_on = 1'b1;
            end
         end
         default: begin
            menu_scr  = SCREEN_MAIN;
            menu_line = OPTION_FIRST;
         end
      endcase
   endfunction

   function automatic panel_status_type panel_tick(input tick_type tk);
      panel_status_type r;
      int               dt;
      int               dg;
      int               tv;
      int               gv;
      int               ang;
      r = '0;
      if (elapsed_cnt < 32'hFFFF) elapsed_cnt++;
      if (elapsed_cnt >= cfg_debounce) begin
         if (!tk.level_a && held_a) begin
            held_a      = 1'b0;
            elapsed_cnt = 0;
            r.press_a   = 1'b1;
            step_line_or_raise();
         end else if (tk.level_a && !held_a) begin
            held_a      = 1'b1;
            elapsed_cnt = 0;
         end
         if (!tk.level_b && held_b) begin
            held_b      = 1'b0;
            elapsed_cnt = 0;
            r.press_b   = 1'b1;
            navigate_screens();
         end else if (tk.level_b && !held_b) begin
            held_b      = 1'b1;
            elapsed_cnt = 0;
         end
      end
      if (tk.sample) begin
         dt = int'(tk.temp) - int'(temp_thr) * (1 << TEMP_FRAC_BITS_DEF);
         dg = int'(tk.gas) - int'(gas_thr);
         if (dt >= 0 || dg >= 0) begin
            tv = 0;
            gv = 0;
            if (dt > 0) tv = (dt * 10) >> TEMP_FRAC_BITS_DEF;
            if (dg > 0) gv = GAS_HALF_STEP * (dg / 10);
            ang = (tv > gv) ? tv : gv;
            if (ang > int'(VENT_MAX)) ang = VENT_MAX;
            alarm         = 1'b1;
            servo         = 6'(ang);
            r.vent_update = 1'b1;
         end else if (alarm) begin
            alarm         = 1'b0;
            servo         = '0;
            r.vent_update = 1'b1;
         end
      end
      r.menu_screen  = menu_scr;
      r.menu_option  = menu_line;
      r.editing      = edit_on;
      r.temp_limit   = temp_thr;
      r.gas_limit    = gas_thr;
      r.alarm_on     = alarm;
      r.vent_angle   = servo;
      r.vent_percent = 7'((int'(servo) * 100) / 45);
      return r;
   endfunction

   function automatic tick_type make_tick(bit a, bit b, bit s, int temp, int gas);
      tick_type tk;
      tk.level_a = a;
      tk.level_b = b;
      tk.sample  = s;
      tk.temp    = 16'(temp);
      tk.gas     = 10'(gas);
      return tk;
   endfunction

   function automatic tick_type random_tick(int toggle_pct, bit use_b);
      int  temp;
      int  gas;
      bit  a;
      bit  b;
      if ($urandom_range(99) < toggle_pct) gen_a = ~gen_a;
      if (use_b && $urandom_range(99) < toggle_pct) gen_b = ~gen_b;
      // occasional one-tick bounce
      a = gen_a ^ ($urandom_range(99) < 4);
      b = use_b ? (gen_b ^ ($urandom_range(99) < 4)) : 1'b1;
      if ($urandom_range(99) < 70) begin
         temp = int'(temp_thr) * 64 + int'($urandom_range(512)) - 192;
         gas  = int'(gas_thr) + int'($urandom_range(160)) - 40;
      end else begin
         temp = int'($urandom_range(TEMP_HI - TEMP_LO)) + TEMP_LO;
         gas  = $urandom_range(GAS_HI);
      end
      if (temp < TEMP_LO) temp = TEMP_LO;
      if (temp > TEMP_HI) temp = TEMP_HI;
      if (gas < 0) gas = 0;
      if (gas > GAS_HI) gas = GAS_HI;
      return make_tick(a, b, $urandom_range(99) < 60, temp, gas);
   endfunction

   task automatic push_tick(input tick_type tk);
      while (tick_q.size() >= 4) @(posedge clock);
      tick_q.push_back(tk);
      n_queued++;
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (n_accepted != n_queued || n_checked != n_accepted);
   endtask

   task automatic run_phase(input int n, input int toggle_pct, input bit use_b);
      repeat (n) push_tick(random_tick(toggle_pct, use_b));
      wait_drained();
   endtask

   task automatic set_config(input logic [15:0] debounce, input logic [6:0] t_ceil,
                             input logic [9:0] g_ceil, input logic [7:0] g_step);
      logic [CSR_DATA_W-1:0] vals[4];
      logic [CSR_INDEX_W-1:0] idx[4];
      vals = '{debounce, 16'(t_ceil), 16'(g_ceil), 16'(g_step)};
      idx  = '{CSR_DEBOUNCE_MS, CSR_TEMP_CEILING, CSR_GAS_CEILING, CSR_GAS_STEP};
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data  <= vals[i];
         do @(posedge clock);
         while (!csr_ready);
      end
      csr_valid     <= 1'b0;
      cfg_debounce  = debounce;
      cfg_temp_ceil = t_ceil;
      cfg_gas_ceil  = g_ceil;
      cfg_gas_step  = g_step;
   endtask

   function automatic int unsigned sender_idle_pct();
      if (n_accepted < 615) return 17;
      if (n_accepted < 1230) return 48;
      return 0;
   endfunction

   function automatic int unsigned receiver_idle_pct();
      if (n_accepted < 615) return 48;
      if (n_accepted < 1230) return 17;
      return 0;
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         n_err++;
      end
   endfunction

   tick_type cur_tick;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_status_q.push_back(panel_tick(cur_tick));
            n_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (tick_q.size() > 0 && $urandom_range(99) >= sender_idle_pct()) begin
               cur_tick   = tick_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {4'b0, cur_tick.gas, cur_tick.temp,
                              cur_tick.level_b, cur_tick.level_a};
               req_tuser  <= cur_tick.sample;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      panel_status_type want;
      panel_status_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = panel_status_type'(rsp_tdata);
            if (expected_status_q.size() == 0) begin
               $error("response beat with no tick pending: %h", rsp_tdata);
               n_err++;
            end else begin
               want = expected_status_q.pop_front();
               check_field("press_a", want.press_a, got.press_a);
               check_field("press_b", want.press_b, got.press_b);
               check_field("menu_screen", want.menu_screen, got.menu_screen);
               check_field("menu_option", want.menu_option, got.menu_option);
               check_field("editing", want.editing, got.editing);
               check_field("temp_limit", want.temp_limit, got.temp_limit);
               check_field("gas_limit", want.gas_limit, got.gas_limit);
               check_field("alarm_on", want.alarm_on, got.alarm_on);
               check_field("vent_angle", want.vent_angle, got.vent_angle);
               check_field("vent_update", want.vent_update, got.vent_update);
               check_field("vent_percent", want.vent_percent, got.vent_percent);
               check_field("pad", want.pad, got.pad);
            end
            n_checked++;
         end
         rsp_tready <= ($urandom_range(99) >= receiver_idle_pct());
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[two_button_menu_threshold_alarm] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // default registers, button two held released
      run_phase(120, 3, 1'b0);

      set_config(16'd0, 7'd127, 10'd1023, 8'd255);
      push_tick(make_tick(1, 1, 1, TEMP_LO, 0));
      push_tick(make_tick(1, 1, 1, TEMP_HI, GAS_HI));
      push_tick(make_tick(1, 1, 1, 0, 0));
      push_tick(make_tick(1, 0, 1, 35 * 64, 0));
      push_tick(make_tick(1, 1, 1, 0, 900));
      push_tick(make_tick(1, 0, 0, 0, 0));
      push_tick(make_tick(0, 1, 0, 0, 0));
      push_tick(make_tick(1, 1, 0, 0, 0));
      push_tick(make_tick(0, 1, 0, 0, 0));
      push_tick(make_tick(1, 0, 0, 0, 0));
      push_tick(make_tick(1, 1, 0, 0, 0));
      push_tick(make_tick(0, 0, 0, 0, 0));
      push_tick(make_tick(1, 1, 0, 0, 0));
      push_tick(make_tick(0, 1, 0, 0, 0));
      push_tick(make_tick(1, 0, 0, 0, 0));
      push_tick(make_tick(1, 1, 0, 0, 0));
      push_tick(make_tick(1, 0, 0, 0, 0));
      push_tick(make_tick(0, 1, 0, 0, 0));
      push_tick(make_tick(1, 1, 1, 36 * 64 + 63, 0));
      push_tick(make_tick(1, 0, 0, 0, 0));
      push_tick(make_tick(1, 1, 0, 0, 0));
      push_tick(make_tick(1, 0, 0, 0, 0));
      push_tick(make_tick(0, 1, 1, 0, GAS_HI));
      push_tick(make_tick(1, 1, 1, 0, GAS_HI - 1));
      push_tick(make_tick(1, 1, 0, -1, 0));
      run_phase(250, 25, 1'b1);

      set_config(16'd3, 7'd0, 10'd0, 8'd1);
      run_phase(300, 25, 1'b1);

      set_config(16'd1, 7'd60, 10'd1000, 8'd0);
      run_phase(300, 25, 1'b1);

      set_config(DEBOUNCE_MS_RST, TEMP_CEILING_RST, GAS_CEILING_RST, GAS_STEP_RST);
      run_phase(300, 4, 1'b1);

      set_config(16'hFFFF, 7'd127, 10'd500, 8'd255);
      run_phase(100, 25, 1'b1);

      set_config(16'd2, 7'd100, 10'd700, 8'd37);
      run_phase(455, 25, 1'b1);

      repeat (8) @(posedge clock);
      if (expected_status_q.size() != 0) begin
         $error("%0d responses never arrived", expected_status_q.size());
         n_err++;
      end
      if (n_err == 0) begin
         $display("[two_button_menu_threshold_alarm] OK");
      end else begin
         $display("[two_button_menu_threshold_alarm] ERROR");
      end
      $finish;
   end

endmodule

FILE: files.f
hdl/tbma_pkg.sv
hdl/tbma_menu.sv
hdl/tbma_vent.sv
hdl/two_button_menu_threshold_alarm.sv
tb/two_button_menu_threshold_alarm_tb.sv
